// ===== src/triangle_obb_overlap_test_top_defines.svh =====
// Assertion macros for the triangle/box overlap test.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef TRIANGLE_OBB_OVERLAP_TEST_TOP_DEFINES_SVH
`define TRIANGLE_OBB_OVERLAP_TEST_TOP_DEFINES_SVH

// same-cycle implication
`define TOBB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tobb port check failed");

// implication with a fixed delay
`define TOBB_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("tobb latency check failed");

`endif

// ===== src/tobb_pkg.sv =====
// Shared widths, constants and register codes for the triangle/box test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tobb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;            // vertex / center coordinate
    localparam int PW        = CW + 1;        // vertex relative to center
    localparam int EW        = PW + 1;        // triangle edge
    localparam int QW        = 16;            // quaternion part, Q1.14
    localparam int QPW       = 2 * QW;        // quaternion part product
    localparam int BXW       = QPW + 2;       // box axis entry
    localparam int AXW       = EW + BXW + 1;  // any tested axis entry
    localparam int DPW       = AXW + PW + 2;  // axis . vertex
    localparam int DBW       = AXW + BXW + 2; // axis . box axis
    localparam int LENW      = 2 * AXW + 2;   // squared axis length
    localparam int EXTW      = 31;
    localparam int RPW       = EXTW + 1 + DBW;
    localparam int CMPW      = LENW;
    localparam int AXIS_SH   = 2 * (QW - 2);  // scale of box axis entries
    localparam int NUM_AXES  = 13;
    localparam int LATENCY   = 14;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 64;

    // 1e-6 as a 2^-64 fraction, moved to the scale of a raw squared length
    localparam logic [63:0] THRESH_Q64 = 64'd18446744073710;
    localparam logic [LENW-1:0] LEN_THRESH = LENW'(THRESH_Q64) << (2 * FRAC_BITS - 8);

    typedef enum logic [CFG_IW-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_HALF_X,
        REG_HALF_Y,
        REG_HALF_Z,
        REG_ORIENTATION
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/tobb_mul.sv =====
// Two-stage signed multiplier built from 33x33 partial products.
// Stand-alone; used by tobb_cross and tobb_axis.
`timescale 1ns / 1ps
`default_nettype none

module tobb_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                     clk,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int RW = AW + BW;

    logic signed [32:0]   ca [NA];
    logic signed [32:0]   cb [NB];
    logic signed [65:0]   pp_reg [NA][NB];
    logic signed [RW-1:0] p_next;
    logic signed [RW-1:0] p_reg;

    // lower chunks unsigned, top chunk carries the sign
    for (genvar i = 0; i < NA; i++) begin : g_ca
        if (i < NA - 1) begin : g_lo
            assign ca[i] = $signed({1'b0, a[32*i +: 32]});
        end else begin : g_hi
            assign ca[i] = 33'(a >>> (32 * i));
        end
    end

    for (genvar j = 0; j < NB; j++) begin : g_cb
        if (j < NB - 1) begin : g_lo
            assign cb[j] = $signed({1'b0, b[32*j +: 32]});
        end else begin : g_hi
            assign cb[j] = 33'(b >>> (32 * j));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= ca[i] * cb[j];
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                p_next = p_next + (RW'(pp_reg[i][j]) <<< (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== src/tobb_cross.sv =====
// Three-stage pipelined cross product of two signed 3-vectors.
// Depends on tobb_mul.
`timescale 1ns / 1ps
`default_nettype none

module tobb_cross #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                       clk,
    input  logic signed [AW-1:0]       a [3],
    input  logic signed [BW-1:0]       b [3],
    output logic signed [AW+BW:0]      r [3]
);

    logic signed [AW+BW-1:0] prod_l [3];
    logic signed [AW+BW-1:0] prod_r [3];
    logic signed [AW+BW:0]   r_reg  [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        tobb_mul #(.AW(AW), .BW(BW)) u_mul_l (
            .clk (clk),
            .a   (a[(k + 1) % 3]),
            .b   (b[(k + 2) % 3]),
            .p   (prod_l[k])
        );
        tobb_mul #(.AW(AW), .BW(BW)) u_mul_r (
            .clk (clk),
            .a   (a[(k + 2) % 3]),
            .b   (b[(k + 1) % 3]),
            .p   (prod_r[k])
        );

        always_ff @(posedge clk)
        begin
            r_reg[k] <= (AW+BW+1)'(prod_l[k]) - (AW+BW+1)'(prod_r[k]);
        end

        assign r[k] = r_reg[k];
    end

endmodule

`default_nettype wire

// ===== src/tobb_axis.sv =====
// Eight-stage separating axis test of one axis against triangle and box.
// Depends on tobb_pkg and tobb_mul.
`timescale 1ns / 1ps
`default_nettype none

module tobb_axis
    import tobb_pkg::*;
(
    input  logic                    clk,
    input  logic signed [AXW-1:0]   a [3],
    input  logic signed [PW-1:0]    p [3][3],
    input  logic signed [BXW-1:0]   bx [3][3],
    input  logic [EXTW-1:0]         ext [3],
    input  logic                    gate_en,
    output logic                    sep
);

    logic signed [AXW+PW-1:0]   dpp [9];
    logic signed [AXW+BXW-1:0]  dbp [9];
    logic signed [2*AXW-1:0]    lpp [3];
    logic signed [RPW-1:0]      rp  [3];
    logic signed [EXTW:0]       ext_s [3];

    logic signed [DPW-1:0]  dp_reg [3];
    logic signed [DBW-1:0]  db_reg [3];
    logic signed [LENW-1:0] len_reg;
    logic signed [DBW-1:0]  abs_reg [3];
    logic signed [DPW-1:0]  dp_pipe_reg [3][3];
    logic [3:0]             len_ok_reg;
    logic signed [CMPW-1:0] rad_reg;
    logic signed [CMPW-1:0] dps_reg [3];
    logic                   sep_reg;
    logic signed [CMPW-1:0] neg_rad;
    logic                   above;
    logic                   below;

    for (genvar m = 0; m < 3; m++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            tobb_mul #(.AW(AXW), .BW(PW)) u_dp (
                .clk (clk), .a (a[c]), .b (p[m][c]), .p (dpp[3*m+c])
            );
            tobb_mul #(.AW(AXW), .BW(BXW)) u_db (
                .clk (clk), .a (a[c]), .b (bx[m][c]), .p (dbp[3*m+c])
            );
        end
        tobb_mul #(.AW(AXW), .BW(AXW)) u_len (
            .clk (clk), .a (a[m]), .b (a[m]), .p (lpp[m])
        );
        assign ext_s[m] = $signed({1'b0, ext[m]});
        tobb_mul #(.AW(EXTW+1), .BW(DBW)) u_rad (
            .clk (clk), .a (ext_s[m]), .b (abs_reg[m]), .p (rp[m])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 3; m++)
        begin
            dp_reg[m] <= DPW'(dpp[3*m]) + DPW'(dpp[3*m+1]) + DPW'(dpp[3*m+2]);
            db_reg[m] <= DBW'(dbp[3*m]) + DBW'(dbp[3*m+1]) + DBW'(dbp[3*m+2]);
            abs_reg[m] <= db_reg[m][DBW-1] ? -db_reg[m] : db_reg[m];
            dp_pipe_reg[0][m] <= dp_reg[m];
            dp_pipe_reg[1][m] <= dp_pipe_reg[0][m];
            dp_pipe_reg[2][m] <= dp_pipe_reg[1][m];
            dps_reg[m] <= CMPW'(dp_pipe_reg[2][m]) <<< AXIS_SH;
        end
        len_reg <= LENW'(lpp[0]) + LENW'(lpp[1]) + LENW'(lpp[2]);
        // degenerate cross axes never separate
        len_ok_reg <= {len_ok_reg[2:0], !gate_en || (len_reg > $signed(LEN_THRESH))};
        rad_reg <= CMPW'(rp[0]) + CMPW'(rp[1]) + CMPW'(rp[2]);
        sep_reg <= len_ok_reg[3] && (above || below);
    end

    always_comb
    begin
        neg_rad = -rad_reg;
        above = (dps_reg[0] > rad_reg) && (dps_reg[1] > rad_reg) && (dps_reg[2] > rad_reg);
        below = (dps_reg[0] < neg_rad) && (dps_reg[1] < neg_rad) && (dps_reg[2] < neg_rad);
    end

    assign sep = sep_reg;

endmodule

`default_nettype wire

// ===== src/triangle_obb_overlap_test_top.sv =====
// Triangle versus oriented box overlap test, top level.
// Depends on tobb_pkg, tobb_cross, tobb_axis.
//
// channel   signals                                    transfer
// input     start, busy, ax..cz, last_triangle         start && !busy
// result    result_valid, triangle_hit, end_of_mesh    result_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One triangle is accepted every cycle; busy stays low.
// Each result follows its transaction through edge setup (p_reg, e_reg),
// the cross products, the axis tests and 1 output register.
// Box axes follow an orientation write through the product registers and box_axis_reg.
// Reset zeroes centers and the valid pipeline, sets half sizes to 1.0 and q to identity; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module triangle_obb_overlap_test_top
    import tobb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CW-1:0]     ax,
    input  logic signed [CW-1:0]     ay,
    input  logic signed [CW-1:0]     az,
    input  logic signed [CW-1:0]     bx,
    input  logic signed [CW-1:0]     by,
    input  logic signed [CW-1:0]     bz,
    input  logic signed [CW-1:0]     cx,
    input  logic signed [CW-1:0]     cy,
    input  logic signed [CW-1:0]     cz,
    input  logic                     last_triangle,
    output logic                     result_valid,
    output logic                     triangle_hit,
    output logic                     end_of_mesh,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data
);

    logic signed [CW-1:0]   center_reg [3];
    logic [EXTW-1:0]        half_reg [3];
    logic [CFG_DW-1:0]      orient_reg;

    logic signed [QW-1:0]   qx, qy, qz, qw;
    logic signed [QPW-1:0]  xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [QPW-1:0]  xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [BXW-1:0]  box_axis_reg [3][3];

    logic                   accept;
    logic [LATENCY-1:0]     vld_reg;
    logic [LATENCY-1:0]     last_reg;
    logic                   hit_reg;

    logic signed [CW-1:0]   vtx [3][3];
    logic signed [PW-1:0]   p_reg [5][3][3];
    logic signed [EW-1:0]   e_reg [3][3];
    logic signed [AXW-1:0]  axis_vec [NUM_AXES][3];
    logic signed [AXW-1:0]  cross_out [9][3];
    logic [NUM_AXES-1:0]    sep;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            half_reg[0]   <= EXTW'(1 << FRAC_BITS);
            half_reg[1]   <= EXTW'(1 << FRAC_BITS);
            half_reg[2]   <= EXTW'(1 << FRAC_BITS);
            orient_reg    <= {2'b01, {(CFG_DW-2){1'b0}}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:    center_reg[0] <= cfg_data[CW-1:0];
                REG_CENTER_Y:    center_reg[1] <= cfg_data[CW-1:0];
                REG_CENTER_Z:    center_reg[2] <= cfg_data[CW-1:0];
                REG_HALF_X:      half_reg[0]   <= cfg_data[EXTW-1:0];
                REG_HALF_Y:      half_reg[1]   <= cfg_data[EXTW-1:0];
                REG_HALF_Z:      half_reg[2]   <= cfg_data[EXTW-1:0];
                REG_ORIENTATION: orient_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // box axes: columns of the rotation matrix of q
    assign qx = orient_reg[QW-1:0];
    assign qy = orient_reg[2*QW-1:QW];
    assign qz = orient_reg[3*QW-1:2*QW];
    assign qw = orient_reg[4*QW-1:3*QW];

    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        ww_reg <= qw * qw;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        wx_reg <= qw * qx;
        wy_reg <= qw * qy;
        wz_reg <= qw * qz;

        box_axis_reg[0][0] <= BXW'(ww_reg) + BXW'(xx_reg) - BXW'(yy_reg) - BXW'(zz_reg);
        box_axis_reg[0][1] <= (BXW'(xy_reg) + BXW'(wz_reg)) <<< 1;
        box_axis_reg[0][2] <= (BXW'(xz_reg) - BXW'(wy_reg)) <<< 1;
        box_axis_reg[1][0] <= (BXW'(xy_reg) - BXW'(wz_reg)) <<< 1;
        box_axis_reg[1][1] <= BXW'(ww_reg) - BXW'(xx_reg) + BXW'(yy_reg) - BXW'(zz_reg);
        box_axis_reg[1][2] <= (BXW'(yz_reg) + BXW'(wx_reg)) <<< 1;
        box_axis_reg[2][0] <= (BXW'(xz_reg) + BXW'(wy_reg)) <<< 1;
        box_axis_reg[2][1] <= (BXW'(yz_reg) - BXW'(wx_reg)) <<< 1;
        box_axis_reg[2][2] <= BXW'(ww_reg) - BXW'(xx_reg) - BXW'(yy_reg) + BXW'(zz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    assign vtx[0][0] = ax;
    assign vtx[0][1] = ay;
    assign vtx[0][2] = az;
    assign vtx[1][0] = bx;
    assign vtx[1][1] = by;
    assign vtx[1][2] = bz;
    assign vtx[2][0] = cx;
    assign vtx[2][1] = cy;
    assign vtx[2][2] = cz;

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[LATENCY-2:0], last_triangle};
        for (int m = 0; m < 3; m++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_reg[0][m][c] <= PW'(vtx[m][c]) - PW'(center_reg[c]);
            end
        end
        for (int s = 1; s < 5; s++)
        begin
            p_reg[s] <= p_reg[s-1];
        end
        for (int c = 0; c < 3; c++)
        begin
            e_reg[0][c] <= EW'(p_reg[0][1][c]) - EW'(p_reg[0][0][c]);
            e_reg[1][c] <= EW'(p_reg[0][2][c]) - EW'(p_reg[0][1][c]);
            e_reg[2][c] <= EW'(p_reg[0][0][c]) - EW'(p_reg[0][2][c]);
        end
        hit_reg <= ~|sep;
    end

    // triangle normal e0 x (p2 - p0), written as e2 x e0
    tobb_cross #(.AW(EW), .BW(EW)) u_normal (
        .clk (clk),
        .a   (e_reg[2]),
        .b   (e_reg[0]),
        .r   (axis_vec[3])
    );

    for (genvar gi = 0; gi < 3; gi++) begin : g_edge
        for (genvar gj = 0; gj < 3; gj++) begin : g_box
            tobb_cross #(.AW(EW), .BW(BXW)) u_cross (
                .clk (clk),
                .a   (e_reg[gi]),
                .b   (box_axis_reg[gj]),
                .r   (cross_out[3*gi+gj])
            );
            assign axis_vec[4+3*gi+gj] = cross_out[3*gi+gj];
        end
    end

    for (genvar gb = 0; gb < 3; gb++) begin : g_boxaxis
        for (genvar gc = 0; gc < 3; gc++) begin : g_c
            assign axis_vec[gb][gc] = AXW'(box_axis_reg[gb][gc]);
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
        tobb_axis u_axis (
            .clk     (clk),
            .a       (axis_vec[k]),
            .p       (p_reg[4]),
            .bx      (box_axis_reg),
            .ext     (half_reg),
            .gate_en ((k >= 4) ? 1'b1 : 1'b0),
            .sep     (sep[k])
        );
    end

    assign result_valid = vld_reg[LATENCY-1];
    assign triangle_hit = hit_reg;
    assign end_of_mesh  = last_reg[LATENCY-1];

endmodule

`default_nettype wire

// ===== src/tobb_checker.sv =====
// Port-level checker for the triangle/box test, bound to the top level.
// Depends on tobb_pkg and triangle_obb_overlap_test_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_obb_overlap_test_top_defines.svh"

module tobb_checker
    import tobb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_triangle,
    input logic result_valid,
    input logic end_of_mesh
);

    // every transaction yields one result at fixed latency, and nothing else does
    `TOBB_ASSERT_DELAY(a_accept_to_result, start && !busy, LATENCY, result_valid)
    `TOBB_ASSERT_IMPL(a_result_had_accept, result_valid, $past(start && !busy, LATENCY))
    `TOBB_ASSERT_IMPL(a_marker_follows, result_valid, end_of_mesh == $past(last_triangle, LATENCY))

endmodule

bind triangle_obb_overlap_test_top tobb_checker u_tobb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .last_triangle (last_triangle),
    .result_valid  (result_valid),
    .end_of_mesh   (end_of_mesh)
);

`default_nettype wire
